// ===== rtl/amsl_pkg.sv =====
// ----------------------------------------------------------------------------
// amsl_pkg - shared types and constants of the soft knee mix limiter
// request payload structs, fixed arithmetic constants and parameter defaults
// ----------------------------------------------------------------------------
package amsl_pkg;

  localparam int unsigned GAIN_FRAC_BITS  = 12;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [15:0] GAIN_RESET      = 16'd4096;
  localparam int unsigned KNEE            = 28000;
  localparam int unsigned KNEE_SPAN       = 4767;
  localparam int unsigned LEVEL_SCALE     = 10000;
  localparam int unsigned FULL_SCALE_BITS = 15;
  localparam int unsigned QUO_W           = 13;

  typedef struct packed {
    logic signed [15:0] voice_sample;
    logic               media_active;
    logic signed [15:0] media_sample;
    logic               stream_active;
    logic signed [15:0] stream_sample;
    logic               last_in_buffer;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_sample;
    logic               level_valid;
    logic [13:0]        buffer_level;
  } out_item_t;

endpackage

// ===== rtl/amsl_front.sv =====
// ----------------------------------------------------------------------------
// amsl_front - request intake, mixing and gain
// saturating mix, magnitude and sign split, gain multiply, knee classification
// ----------------------------------------------------------------------------
module amsl_front #(
  parameter int unsigned GAIN_FRAC_BITS = amsl_pkg::GAIN_FRAC_BITS,
  parameter int unsigned MAG_W          = 31 - GAIN_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  amsl_pkg::in_item_t   in_item_i,
  output logic                 push_o,
  input  logic                 full_i,
  output logic [MAG_W+2:0]     entry_o
);

  function automatic logic signed [16:0] sat16(input logic signed [16:0] s);
    logic signed [16:0] r;
    if (s > 17'sd32767) begin
      r = 17'sd32767;
    end else if (s < -17'sd32768) begin
      r = -17'sd32768;
    end else begin
      r = s;
    end
    return r;
  endfunction

  logic [15:0]        gain_q;
  logic               a_valid_q;
  logic [15:0]        a_mag_q, a_mag_d;
  logic               a_neg_q, a_neg_d;
  logic               a_last_q;
  logic signed [16:0] mix1, mix2, mag17;
  logic [31:0]        prod;
  logic [31:0]        gained;
  logic [MAG_W-1:0]   mag;
  logic               knee;
  logic               accept;

  assign in_ready_o = !a_valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = a_valid_q && !full_i;

  always_comb begin
    mix1 = sat16({in_item_i.voice_sample[15], in_item_i.voice_sample} +
                 (in_item_i.media_active ?
                  {in_item_i.media_sample[15], in_item_i.media_sample} : 17'sd0));
    mix2 = sat16(mix1 +
                 (in_item_i.stream_active ?
                  {in_item_i.stream_sample[15], in_item_i.stream_sample} : 17'sd0));
    a_neg_d = mix2[16];
    mag17   = a_neg_d ? -mix2 : mix2;
    a_mag_d = mag17[15:0];
  end

  // product is below 2^31, so the shifted magnitude fits MAG_W bits
  always_comb begin
    prod    = a_mag_q * gain_q;
    gained  = prod >> GAIN_FRAC_BITS;
    mag     = gained[MAG_W-1:0];
    knee    = mag > MAG_W'(amsl_pkg::KNEE);
    entry_o = {a_neg_q, a_last_q, knee, mag};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q    <= amsl_pkg::GAIN_RESET;
      a_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (push_o) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_mag_q  <= a_mag_d;
      a_neg_q  <= a_neg_d;
      a_last_q <= in_item_i.last_in_buffer;
    end
  end

endmodule

// ===== rtl/amsl_queue.sv =====
// ----------------------------------------------------------------------------
// amsl_queue - short request queue between front and back
// register based ring buffer with fill count
// ----------------------------------------------------------------------------
module amsl_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = amsl_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = count_q == CNT_W'(DEPTH);
  assign valid_o = count_q != '0;
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/amsl_back.sv =====
// ----------------------------------------------------------------------------
// amsl_back - soft knee, peak tracking and result register
// sequencer around a restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module amsl_back #(
  parameter int unsigned MAG_W = 19
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  logic [MAG_W+2:0]     q_entry_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output amsl_pkg::out_item_t  out_item_o
);

  localparam int unsigned QUO_W = amsl_pkg::QUO_W;
  localparam int unsigned NUM_W = MAG_W + QUO_W;
  localparam int unsigned DSH_W = MAG_W + QUO_W - 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } back_state_e;

  back_state_e         state_q, state_d;
  logic                neg_q, neg_d;
  logic                last_q, last_d;
  logic [MAG_W-1:0]    mag_q, mag_d;
  logic [MAG_W-1:0]    over_q, over_d;
  logic [MAG_W-1:0]    den_q, den_d;
  logic [NUM_W-1:0]    rem_q, rem_d;
  logic [DSH_W-1:0]    dsh_q, dsh_d;
  logic [QUO_W-1:0]    quo_q, quo_d;
  logic [3:0]          cnt_q, cnt_d;
  logic [14:0]         res_q, res_d;
  logic [14:0]         peak_q, peak_d;
  logic                out_valid_q, out_valid_d;
  amsl_pkg::out_item_t out_q, out_d;
  logic                ge;
  logic                fire;
  logic [14:0]         new_peak;
  logic [28:0]         lev_prod;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign fire        = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    last_d      = last_q;
    mag_d       = mag_q;
    over_d      = over_q;
    den_d       = den_q;
    rem_d       = rem_q;
    dsh_d       = dsh_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    peak_d      = peak_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    q_pop_o     = 1'b0;
    ge          = rem_q >= NUM_W'(dsh_q);
    new_peak    = (res_q > peak_q) ? res_q : peak_q;
    lev_prod    = new_peak * 14'(amsl_pkg::LEVEL_SCALE);

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          neg_d   = q_entry_i[MAG_W+2];
          last_d  = q_entry_i[MAG_W+1];
          mag_d   = q_entry_i[MAG_W-1:0];
          if (q_entry_i[MAG_W]) begin
            state_d = ST_PREP;
          end else begin
            res_d   = q_entry_i[14:0];
            state_d = ST_FIN;
          end
        end
      end
      ST_PREP: begin
        over_d  = mag_q - MAG_W'(amsl_pkg::KNEE);
        den_d   = mag_q - MAG_W'(amsl_pkg::KNEE - amsl_pkg::KNEE_SPAN);
        state_d = ST_MUL;
      end
      ST_MUL: begin
        rem_d   = NUM_W'(over_q) * NUM_W'(amsl_pkg::KNEE_SPAN);
        dsh_d   = {den_q, {(QUO_W - 1){1'b0}}};
        quo_d   = '0;
        cnt_d   = 4'(QUO_W - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // quotient stays below the knee span, so QUO_W bits cover it
        if (ge) begin
          rem_d = rem_q - NUM_W'(dsh_q);
        end
        quo_d = {quo_q[QUO_W-2:0], ge};
        dsh_d = dsh_q >> 1;
        if (cnt_q == 4'd0) begin
          res_d   = 15'(amsl_pkg::KNEE) + 15'(quo_d);
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_FIN: begin
        if (fire) begin
          out_valid_d            = 1'b1;
          out_d.out_sample       = neg_q ? -$signed({1'b0, res_q}) : $signed({1'b0, res_q});
          out_d.level_valid      = last_q;
          out_d.buffer_level     = last_q ? lev_prod[28:amsl_pkg::FULL_SCALE_BITS] : 14'd0;
          peak_d                 = last_q ? 15'd0 : new_peak;
          state_d                = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      peak_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      peak_q      <= peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    last_q <= last_d;
    mag_q  <= mag_d;
    over_q <= over_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

endmodule

// ===== rtl/audio_mix_soft_knee_limiter_unit.sv =====
// path: front register, queue, then back states IDLE and FIN below the knee, and
//   IDLE, PREP, MUL, the 13-step restoring divider of the soft knee and FIN above it;
//   back pops only from IDLE; front takes one per cycle while the queue is not full
// reset: asynchronous active low, gain returns to unity, peak and queue clear,
//   no clearing pass
// ----------------------------------------------------------------------------
// audio_mix_soft_knee_limiter_unit - mixer with gain and soft knee limiter
// three-source saturating mix, output gain, rational soft knee, buffer level
// ----------------------------------------------------------------------------
module audio_mix_soft_knee_limiter_unit #(
  parameter int unsigned GAIN_FRAC_BITS = amsl_pkg::GAIN_FRAC_BITS,
  parameter int unsigned QUEUE_DEPTH    = amsl_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  amsl_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output amsl_pkg::out_item_t out_item_o
);

  // gained magnitude width: product stays below 2^31
  localparam int unsigned MAG_W = 31 - GAIN_FRAC_BITS;
  // queue entry: sign, buffer end, knee flag, gained magnitude
  localparam int unsigned ENT_W = MAG_W + 3;

  logic             push;
  logic             full;
  logic [ENT_W-1:0] push_entry;
  logic             q_valid;
  logic             q_pop;
  logic [ENT_W-1:0] q_entry;

  // front: takes a request, mixes and applies gain, classifies against the knee
  amsl_front #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
    .MAG_W         (MAG_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .full_i     (full),
    .entry_o    (push_entry)
  );

  // queue decouples intake from the slow knee path
  amsl_queue #(
    .WIDTH(ENT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(push_entry),
    .full_o (full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .rdata_o(q_entry)
  );

  // back: knee division, peak tracking, level report and result register
  amsl_back #(
    .MAG_W(MAG_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_entry),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

// ===== rtl/amsl_checker.sv =====
// ----------------------------------------------------------------------------
// amsl_checker - port level checks of the mix limiter
// result stability and range of the limited sample and level fields
// ----------------------------------------------------------------------------
module amsl_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input amsl_pkg::out_item_t out_item_o
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("result changed while stalled");

  // level is zero away from a buffer end
  a_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.level_valid) |-> (out_item_o.buffer_level == 14'd0))
    else $error("level set without buffer end");

  // level stays in its scaled range
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.buffer_level <= 14'd9999))
    else $error("level out of range");

  // knee keeps the magnitude below full scale
  a_sample_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.out_sample != -16'sd32768 &&
                     out_item_o.out_sample != 16'sd32767))
    else $error("limited sample reached full scale");

endmodule

bind audio_mix_soft_knee_limiter_unit amsl_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - mixer, gain and soft knee limiter check
// drives slot requests through the valid/ready channels under random idling,
// predicts each limited sample and buffer level, and compares them in order
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CYCLE_LIMIT      = 600000;
  localparam int unsigned RAND_REQUESTS    = 1000;
  localparam int unsigned GAIN_PHASES      = 8;
  localparam int unsigned LONG_HOLD_CYCLES = 400;

  // expected sample and level queue with its own copy of gain and peak
  class mix_scoreboard;
    logic [15:0]         gain;
    logic [14:0]         peak;
    amsl_pkg::out_item_t expected_q[$];
    int unsigned         mismatches;

    function new();
      gain       = amsl_pkg::GAIN_RESET;
      peak       = '0;
      mismatches = 0;
    endfunction

    function int sat16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void note_request(amsl_pkg::in_item_t it);
      int                  mix;
      bit                  neg;
      longint unsigned     mag;
      longint unsigned     over;
      longint              signed_mag;
      amsl_pkg::out_item_t res;
      mix = $signed(it.voice_sample);
      if (it.media_active) mix = sat16(mix + $signed(it.media_sample));
      if (it.stream_active) mix = sat16(mix + $signed(it.stream_sample));
      neg = (mix < 0);
      mag = neg ? longint'(-mix) : longint'(mix);
      mag = (mag * longint'(gain)) >> amsl_pkg::GAIN_FRAC_BITS;
      // rational soft knee above the threshold
      if (mag > amsl_pkg::KNEE) begin
        over = mag - amsl_pkg::KNEE;
        mag  = amsl_pkg::KNEE + (over * amsl_pkg::KNEE_SPAN) / (over + amsl_pkg::KNEE_SPAN);
      end
      if (mag[31:0] > {17'd0, peak}) peak = mag[14:0];
      res.level_valid  = it.last_in_buffer;
      res.buffer_level = '0;
      if (it.last_in_buffer) begin
        res.buffer_level = 14'((longint'(peak) * amsl_pkg::LEVEL_SCALE) >>
                               amsl_pkg::FULL_SCALE_BITS);
        peak = '0;
      end
      signed_mag     = neg ? -longint'(mag) : longint'(mag);
      res.out_sample = 16'(signed_mag);
      expected_q.push_back(res);
    endfunction

    function void check_result(amsl_pkg::out_item_t got);
      amsl_pkg::out_item_t exp_res;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none, actual %0d/%0b/%0d", $time,
                 got.out_sample, got.level_valid, got.buffer_level);
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.out_sample !== exp_res.out_sample) begin
        mismatches++;
        $display("%0t out_sample mismatch: expected %0d, actual %0d", $time,
                 exp_res.out_sample, got.out_sample);
      end
      if (got.level_valid !== exp_res.level_valid) begin
        mismatches++;
        $display("%0t level_valid mismatch: expected %0b, actual %0b", $time,
                 exp_res.level_valid, got.level_valid);
      end
      if (got.buffer_level !== exp_res.buffer_level) begin
        mismatches++;
        $display("%0t buffer_level mismatch: expected %0d, actual %0d", $time,
                 exp_res.buffer_level, got.buffer_level);
      end
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [15:0]         cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  amsl_pkg::in_item_t  in_item_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  amsl_pkg::out_item_t out_item_o;

  mix_scoreboard sb;
  int unsigned   cycle_count = 0;
  int unsigned   holds_asked = 0;
  int unsigned   holds_done  = 0;
  int unsigned   buf_left    = 0;

  audio_mix_soft_knee_limiter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random ready gaps, free-running stretches, long holds on demand
  initial begin : result_sink
    int unsigned gap_left;
    int unsigned free_left;
    int unsigned hold_left;
    int unsigned pick;
    gap_left  = 0;
    free_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_item_o);
      if (holds_done != holds_asked) begin
        hold_left = LONG_HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        out_ready_i <= 1'b0;
        gap_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (free_left > 0) begin
          free_left--;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 2) free_left = 300;
          else if (pick < 25) gap_left = $urandom_range(1, 3);
          else if (pick < 28) gap_left = $urandom_range(20, 60);
        end
      end
    end
  end

  function automatic amsl_pkg::in_item_t slot_request(int voice, bit media_on, int media,
                                                      bit stream_on, int stream, bit last);
    amsl_pkg::in_item_t it;
    it.voice_sample   = 16'(voice);
    it.media_active   = media_on;
    it.media_sample   = 16'(media);
    it.stream_active  = stream_on;
    it.stream_sample  = 16'(stream);
    it.last_in_buffer = last;
    return it;
  endfunction

  // full-scale and near-zero values show up often, the rest is uniform
  function automatic logic [15:0] pick_sample();
    unique case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return $urandom_range(0, 1) ? 16'h0001 : 16'hffff;
      3:       return 16'(int'($urandom_range(0, 800)) - 400);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int unsigned sender_gap(bit dense);
    int unsigned pick;
    if (dense) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(input amsl_pkg::in_item_t it, input int unsigned gap);
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(it);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_gain(input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.gain = value;
  endtask

  // well-formed device buffers of random length, random content
  task automatic send_random(input bit dense);
    amsl_pkg::in_item_t it;
    it.voice_sample  = pick_sample();
    it.media_active  = ($urandom_range(0, 3) != 0);
    it.media_sample  = pick_sample();
    it.stream_active = ($urandom_range(0, 2) != 0);
    it.stream_sample = pick_sample();
    if (buf_left == 0) buf_left = $urandom_range(1, 24);
    buf_left--;
    it.last_in_buffer = (buf_left == 0);
    send_request(it, sender_gap(dense));
  endtask

  initial begin : stimulus
    logic [15:0] phase_gain [GAIN_PHASES];
    int unsigned per_phase;
    sb = new();
    phase_gain = '{16'hffff, 16'h0000, 16'h0001, amsl_pkg::GAIN_RESET, 16'd2048, 16'd8192,
                   16'($urandom), 16'($urandom_range(4096, 12000))};
    per_phase = RAND_REQUESTS / GAIN_PHASES;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed slots at unity gain
    write_gain(amsl_pkg::GAIN_RESET);
    send_request(slot_request(0, 0, 0, 0, 0, 1), 0);                   // level of empty buffer
    send_request(slot_request(32767, 0, 0, 0, 0, 0), 1);
    send_request(slot_request(-32768, 0, 0, 0, 0, 0), 0);              // knee on full negative
    send_request(slot_request(32767, 1, 32767, 0, 0, 0), 2);           // positive saturation
    send_request(slot_request(-32768, 1, -1, 1, -32768, 0), 0);        // negative saturation
    send_request(slot_request(100, 0, -32768, 0, 32767, 1), 0);        // inactive sources ignored
    send_request(slot_request(30000, 1, 10000, 1, -10000, 0), 0);      // saturate before stream
    send_request(slot_request(-30000, 1, -10000, 1, 10000, 0), 3);
    send_request(slot_request(28000, 0, 0, 0, 0, 0), 0);               // right at the knee
    send_request(slot_request(28001, 0, 0, 0, 0, 1), 0);
    send_request(slot_request(-1, 0, 0, 1, 1, 1), 0);                  // back-to-back buffer ends
    send_request(slot_request(1, 1, -1, 1, -1, 1), 0);
    wait_drained();
    write_gain(16'hffff);                                             // largest gained magnitude
    send_request(slot_request(-32768, 0, 0, 0, 0, 1), 0);
    send_request(slot_request(1, 0, 0, 0, 0, 0), 0);
    send_request(slot_request(7, 1, 0, 1, 0, 1), 0);
    wait_drained();
    write_gain(16'h0000);                                             // gain of zero
    send_request(slot_request(32767, 1, 32767, 1, 32767, 1), 0);
    wait_drained();

    for (int p = 0; p < GAIN_PHASES; p++) begin
      write_gain(phase_gain[p]);
      for (int n = 0; n < per_phase; n++) begin
        // receiver stops long enough for the block to back up its input
        if (p == 3 && n == 5) holds_asked++;
        // sender waits for everything outstanding mid-phase
        if (p == 5 && n == 60) wait_drained();
        send_random(p == 4);
      end
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== audio_mix_soft_knee_limiter_unit.f =====
rtl/amsl_pkg.sv
rtl/amsl_front.sv
rtl/amsl_queue.sv
rtl/amsl_back.sv
rtl/audio_mix_soft_knee_limiter_unit.sv
rtl/amsl_checker.sv
sim/testbench.sv
